### design/spen_pkg.sv
// Shared types and constants for the sky polygon edge normals unit.
package spen_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    // ceil(2^28 / 45): exact quotient by 45 for dividends below 45 * 2^16
    localparam logic [22:0] DIV45_RECIP = 23'd5965233;
    // 92 * 45 * 2^32: keeps the phase dividend non-negative, no effect on the phase
    localparam logic [47:0] PHASE_BIAS = 48'd4140 << 32;

    typedef struct packed {
        logic [24:0]        ra;
        logic signed [23:0] dec;
        logic               last;
    } vtx_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PHASE,
        BK_CORDIC,
        BK_VEC,
        BK_CROSS,
        BK_OUT
    } bk_state_t;

    function automatic logic signed [33:0] atan_phase(input logic [4:0] i);
        case (i)
            5'd0: atan_phase = 34'sd536870912;
            5'd1: atan_phase = 34'sd316933406;
            5'd2: atan_phase = 34'sd167458907;
            5'd3: atan_phase = 34'sd85004756;
            5'd4: atan_phase = 34'sd42667331;
            5'd5: atan_phase = 34'sd21354465;
            5'd6: atan_phase = 34'sd10679838;
            5'd7: atan_phase = 34'sd5340245;
            5'd8: atan_phase = 34'sd2670163;
            5'd9: atan_phase = 34'sd1335087;
            5'd10: atan_phase = 34'sd667544;
            5'd11: atan_phase = 34'sd333772;
            5'd12: atan_phase = 34'sd166886;
            5'd13: atan_phase = 34'sd83443;
            5'd14: atan_phase = 34'sd41722;
            5'd15: atan_phase = 34'sd20861;
            5'd16: atan_phase = 34'sd10430;
            5'd17: atan_phase = 34'sd5215;
            5'd18: atan_phase = 34'sd2608;
            5'd19: atan_phase = 34'sd1304;
            5'd20: atan_phase = 34'sd652;
            5'd21: atan_phase = 34'sd326;
            5'd22: atan_phase = 34'sd163;
            5'd23: atan_phase = 34'sd81;
            5'd24: atan_phase = 34'sd41;
            5'd25: atan_phase = 34'sd20;
            5'd26: atan_phase = 34'sd10;
            5'd27: atan_phase = 34'sd5;
            5'd28: atan_phase = 34'sd3;
            5'd29: atan_phase = 34'sd1;
            default: atan_phase = 34'sd0;
        endcase
    endfunction

endpackage

### design/spen_if.sv
// Valid/ready channel interfaces for vertices and edge normals.
interface spen_vtx_if;
    logic               valid;
    logic               ready;
    logic [24:0]        ra_deg;
    logic signed [23:0] dec_deg;
    logic               last_vertex;
    modport source (output valid, ra_deg, dec_deg, last_vertex, input ready);
    modport sink (input valid, ra_deg, dec_deg, last_vertex, output ready);
endinterface

interface spen_nrm_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic               closing_edge;
    modport source (output valid, normal_x, normal_y, normal_z, closing_edge, input ready);
    modport sink (input valid, normal_x, normal_y, normal_z, closing_edge, output ready);
endinterface

### design/sky_polygon_edge_normals_unit.sv
// Top level: vertex queue front end feeding the edge normal back end.
// Path from vertex accept to a normal: pop, phase, CORDIC, vector, cross-product and output states;
// a closing normal takes a further cross-product and output pass.
// The back end holds one vertex at a time, through all of its normals and any output stalls;
// a two-entry queue takes vertices meanwhile.
// Reset: asynchronous, active low; clears queue, stored vectors and polygon state.
module sky_polygon_edge_normals_unit
    import spen_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int VECTOR_FRAC_BITS = 30
)
(
    input logic clk,
    input logic rst_n,
    spen_vtx_if.sink vin,
    spen_nrm_if.source nout
);
    logic q_valid, q_pop;
    vtx_t q_data;

    spen_front u_front (
        .clk(clk), .rst_n(rst_n), .vin(vin),
        .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
    );

    spen_back #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
        .VECTOR_FRAC_BITS(VECTOR_FRAC_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop), .nout(nout)
    );
endmodule

### design/spen_front.sv
// Front end: accepts vertices into a two-entry queue.
module spen_front
    import spen_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    spen_vtx_if.sink vin,
    output logic  q_valid,
    output vtx_t  q_data,
    input  logic  q_pop
);
    vtx_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign vin.ready = (cnt_reg != 2'd2);
    assign push = vin.valid && vin.ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= '{ra: vin.ra_deg, dec: vin.dec_deg, last: vin.last_vertex};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (q_pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> cnt_reg != 2'd0) else $error("queue underflow");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("bad count");
endmodule

### design/spen_back.sv
// Back end: phase division by 45, CORDIC sin/cos, vector build, cross products and result register.
module spen_back
    import spen_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int VECTOR_FRAC_BITS = 30
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic  q_valid,
    input  vtx_t  q_data,
    output logic  q_pop,
    spen_nrm_if.source nout
);
    localparam int SH = 32 - ANGLE_FRAC_BITS;
    localparam int PH_SH = SH - 3;
    localparam logic signed [63:0] LIM = 64'sd1 <<< VECTOR_FRAC_BITS;

    bk_state_t state_reg, state_next;
    logic [4:0]  it_reg;
    logic [3:0]  k_reg;
    logic        last_reg, inpoly_reg, first_reg;
    // two CORDIC lanes: 0 = ra, 1 = dec
    logic signed [33:0] x_reg [2];
    logic signed [33:0] y_reg [2];
    logic signed [33:0] z_reg [2];
    logic               neg_reg [2];
    logic [47:0]        nd_reg [2];
    logic [5:0]         rem_reg [2];
    logic [31:0]        ph_reg [2];
    logic signed [31:0] cur_reg [3];
    logic signed [31:0] first_reg_v [3];
    logic signed [31:0] prev_reg [3];
    logic signed [63:0] p_reg;
    logic signed [31:0] n_reg [3];
    logic               closing_reg;
    logic signed [63:0] t_reg [2];

    function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
        logic signed [63:0] r;
        begin
            r = v;
            if (s > 0) r = (v + (64'sd1 <<< (s - 1))) >>> s;
            rnd = r;
        end
    endfunction

    function automatic logic signed [63:0] clampm(input logic signed [63:0] v,
                                                  input logic signed [63:0] l);
        logic signed [63:0] r;
        begin
            r = v;
            if (v > l) r = l;
            else if (v < -l) r = -l;
            clampm = r;
        end
    endfunction

    // phase = floor((a * 2^SH + 180) / 360) = floor(n / 45), n = a * 2^(SH-3) + 22;
    // n is biased non-negative and divided by 45 one 16-bit digit per cycle
    logic signed [47:0] ang_ext [2];
    logic [47:0]        nd0 [2];
    logic [21:0]        dx [2];
    logic [44:0]        dprod [2];
    logic [15:0]        dq [2];
    logic [5:0]         dr [2];
    logic signed [33:0] z0 [2];
    logic signed [33:0] zf [2];
    logic               nf [2];

    always_comb
    begin
        ang_ext[0] = 48'($signed({1'b0, q_data.ra}));
        ang_ext[1] = 48'(q_data.dec);
        for (int l = 0; l < 2; l++)
        begin
            nd0[l] = $unsigned(ang_ext[l] <<< PH_SH) + 48'd22 + PHASE_BIAS;
            dx[l] = {rem_reg[l], nd_reg[l][47:32]};
            dprod[l] = 45'(dx[l]) * 45'(DIV45_RECIP);
            dq[l] = dprod[l][43:28];
            dr[l] = 6'(dx[l] - 22'(dq[l]) * 22'd45);
            z0[l] = 34'($signed(ph_reg[l]));
            zf[l] = z0[l];
            nf[l] = 1'b0;
            if (z0[l] > 34'sd1073741824) begin zf[l] = z0[l] - 34'sd2147483648; nf[l] = 1'b1; end
            else if (z0[l] < -34'sd1073741824) begin zf[l] = z0[l] + 34'sd2147483648; nf[l] = 1'b1; end
        end
    end

    logic signed [31:0] a_sel, b_sel, c_sel, d_sel;
    logic signed [31:0] sc [4];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            sc[2*l]   = 32'(clampm(neg_reg[l] ? -64'(x_reg[l]) : 64'(x_reg[l]), 64'sd1 <<< 30));
            sc[2*l+1] = 32'(clampm(neg_reg[l] ? -64'(y_reg[l]) : 64'(y_reg[l]), 64'sd1 <<< 30));
        end
    end

    // cross operands: first operand vec A, second B
    logic signed [31:0] va [3];
    logic signed [31:0] vb [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            va[k] = closing_reg ? cur_reg[k] : prev_reg[k];
            vb[k] = closing_reg ? first_reg_v[k] : cur_reg[k];
        end
        a_sel = '0; b_sel = '0;
        case (k_reg)
            4'd0: begin a_sel = va[1]; b_sel = vb[2]; end
            4'd1: begin a_sel = va[2]; b_sel = vb[1]; end
            4'd2: begin a_sel = va[2]; b_sel = vb[0]; end
            4'd3: begin a_sel = va[0]; b_sel = vb[2]; end
            4'd4: begin a_sel = va[0]; b_sel = vb[1]; end
            4'd5: begin a_sel = va[1]; b_sel = vb[0]; end
            default: ;
        endcase
        c_sel = sc[0];
        d_sel = sc[2];
    end

    assign q_pop = (state_reg == BK_IDLE) && q_valid;
    assign nout.valid = (state_reg == BK_OUT);
    assign nout.normal_x = n_reg[0];
    assign nout.normal_y = n_reg[1];
    assign nout.normal_z = n_reg[2];
    assign nout.closing_edge = closing_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (q_valid) state_next = BK_PHASE;
            BK_PHASE: if (k_reg == 4'd3) state_next = BK_CORDIC;
            BK_CORDIC: if (it_reg == 5'(CORDIC_STEPS - 1)) state_next = BK_VEC;
            BK_VEC: if (k_reg == 4'd2) state_next = (first_reg && !last_reg) ? BK_IDLE : BK_CROSS;
            BK_CROSS: if (k_reg == 4'd6) state_next = BK_OUT;
            BK_OUT: if (nout.ready) state_next = (closing_reg || !last_reg) ? BK_IDLE : BK_CROSS;
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            inpoly_reg <= 1'b0;
            for (int k = 0; k < 3; k++) begin first_reg_v[k] <= '0; prev_reg[k] <= '0; end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_VEC && k_reg == 4'd2)
            begin
                if (first_reg)
                    for (int k = 0; k < 3; k++)
                    begin
                        first_reg_v[k] <= cur_reg[k];
                        prev_reg[k] <= cur_reg[k];
                    end
                inpoly_reg <= !last_reg;
            end
            // a later vertex becomes prev only once its edge normal has gone out
            if (state_reg == BK_OUT && nout.ready && !closing_reg)
                for (int k = 0; k < 3; k++) prev_reg[k] <= cur_reg[k];
        end
    end

    logic signed [63:0] prod;
    assign prod = 64'(a_sel) * 64'(b_sel);

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                it_reg <= '0;
                k_reg <= '0;
                last_reg <= q_data.last;
                first_reg <= !inpoly_reg;
                closing_reg <= 1'b0;
                for (int l = 0; l < 2; l++)
                begin
                    nd_reg[l] <= nd0[l];
                    rem_reg[l] <= '0;
                end
            end
            BK_PHASE:
            begin
                if (k_reg == 4'd3)
                begin
                    it_reg <= '0;
                    k_reg <= '0;
                    for (int l = 0; l < 2; l++)
                    begin
                        x_reg[l] <= CORDIC_GAIN;
                        y_reg[l] <= '0;
                        z_reg[l] <= zf[l];
                        neg_reg[l] <= nf[l];
                    end
                end
                else
                begin
                    // top digit is dropped, the low two form the 32-bit phase
                    k_reg <= k_reg + 4'd1;
                    for (int l = 0; l < 2; l++)
                    begin
                        rem_reg[l] <= dr[l];
                        nd_reg[l] <= nd_reg[l] << 16;
                        ph_reg[l] <= {ph_reg[l][15:0], dq[l]};
                    end
                end
            end
            BK_CORDIC:
            begin
                it_reg <= it_reg + 5'd1;
                for (int l = 0; l < 2; l++)
                begin
                    if (!z_reg[l][33])
                    begin
                        x_reg[l] <= x_reg[l] - (y_reg[l] >>> it_reg);
                        y_reg[l] <= y_reg[l] + (x_reg[l] >>> it_reg);
                        z_reg[l] <= z_reg[l] - atan_phase(it_reg);
                    end
                    else
                    begin
                        x_reg[l] <= x_reg[l] + (y_reg[l] >>> it_reg);
                        y_reg[l] <= y_reg[l] - (x_reg[l] >>> it_reg);
                        z_reg[l] <= z_reg[l] + atan_phase(it_reg);
                    end
                end
            end
            BK_VEC:
            begin
                // step 0: products, 1: rounding to vector, 2: commit
                k_reg <= k_reg + 4'd1;
                if (k_reg == 4'd0)
                begin
                    t_reg[0] <= rnd(64'(c_sel) * 64'(d_sel), 30);
                    t_reg[1] <= rnd(64'(sc[1]) * 64'(d_sel), 30);
                end
                else if (k_reg == 4'd1)
                begin
                    cur_reg[0] <= 32'(clampm(rnd(t_reg[0], 30 - VECTOR_FRAC_BITS), LIM));
                    cur_reg[1] <= 32'(clampm(rnd(t_reg[1], 30 - VECTOR_FRAC_BITS), LIM));
                    cur_reg[2] <= 32'(clampm(rnd(64'(sc[3]), 30 - VECTOR_FRAC_BITS), LIM));
                end
                else
                begin
                    k_reg <= '0;
                    closing_reg <= first_reg;
                end
            end
            BK_CROSS:
            begin
                k_reg <= k_reg + 4'd1;
                if (k_reg[0] == 1'b0 && k_reg != 4'd6) p_reg <= prod;
                else if (k_reg != 4'd6)
                    n_reg[k_reg[2:1]] <= 32'(clampm(rnd(p_reg - prod, VECTOR_FRAC_BITS), LIM));
            end
            BK_OUT:
            begin
                k_reg <= '0;
                if (nout.ready && !closing_reg) closing_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == BK_PHASE) else $error("pop without start");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        nout.valid && !nout.ready |=> nout.valid && $stable(n_reg[0])) else $error("result lost");
    a_cordic_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_CORDIC |-> it_reg < 5'(CORDIC_STEPS)) else $error("cordic overrun");
endmodule

### sim/tb.sv
// Testbench for sky_polygon_edge_normals_unit: directed and random vertex items, scoreboard check.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import spen_pkg::*;

    typedef struct {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic               closing;
    } normal_t;

    int error_count = 0;

    task automatic report(input string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    class normal_board;
        normal_t expected_normals[$];
        logic signed [31:0] first_vec[3];
        logic signed [31:0] prev_vec[3];
        bit open_polygon;

        function new();
            for (int k = 0; k < 3; k++) begin
                first_vec[k] = 0;
                prev_vec[k] = 0;
            end
            open_polygon = 0;
        endfunction

        function longint floor_sh(longint v, int s);
            return v >>> s;
        endfunction

        function longint round_sh(longint v, int s);
            if (s == 0)
                return v;
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function longint clamp(longint v, longint lim);
            if (v > lim)
                return lim;
            if (v < -lim)
                return -lim;
            return v;
        endfunction

        function void sincos(longint ang, output longint s, output longint c);
            longint num, p, z, x, y, dx, dy;
            logic [31:0] ph;
            bit neg;
            num = ang * (longint'(1) << 16) + 180;
            if (num >= 0)
                p = num / 360;
            else
                p = -((-num + 359) / 360);
            ph = p[31:0];
            z = longint'($signed(ph));
            neg = 0;
            x = CORDIC_GAIN;
            y = 0;
            if (z > (longint'(1) << 30)) begin
                z -= longint'(1) << 31;
                neg = 1;
            end
            else if (z < -(longint'(1) << 30)) begin
                z += longint'(1) << 31;
                neg = 1;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = floor_sh(y, i);
                dy = floor_sh(x, i);
                if (z >= 0) begin
                    x -= dx;
                    y += dy;
                    z -= atan_phase(i[4:0]);
                end
                else begin
                    x += dx;
                    y -= dy;
                    z += atan_phase(i[4:0]);
                end
            end
            if (neg) begin
                x = -x;
                y = -y;
            end
            c = clamp(x, longint'(1) << 30);
            s = clamp(y, longint'(1) << 30);
        endfunction

        function normal_t cross_prod(logic signed [31:0] a[3], logic signed [31:0] b[3],
                                     logic closing);
            normal_t r;
            longint n[3];
            longint lim;
            lim = longint'(1) << 30;
            n[0] = longint'(a[1]) * b[2] - longint'(a[2]) * b[1];
            n[1] = longint'(a[2]) * b[0] - longint'(a[0]) * b[2];
            n[2] = longint'(a[0]) * b[1] - longint'(a[1]) * b[0];
            r.nx = 32'(clamp(round_sh(n[0], 30), lim));
            r.ny = 32'(clamp(round_sh(n[1], 30), lim));
            r.nz = 32'(clamp(round_sh(n[2], 30), lim));
            r.closing = closing;
            return r;
        endfunction

        function void note_vertex(logic [24:0] ra, logic signed [23:0] dec, logic last);
            longint sr, cr, sd, cd;
            logic signed [31:0] cur[3];
            sincos(longint'(ra), sr, cr);
            sincos(longint'(dec), sd, cd);
            cur[0] = 32'(clamp(round_sh(cr * cd, 30), longint'(1) << 30));
            cur[1] = 32'(clamp(round_sh(sr * cd, 30), longint'(1) << 30));
            cur[2] = 32'(clamp(sd, longint'(1) << 30));
            if (!open_polygon) begin
                first_vec = cur;
                open_polygon = 1;
            end
            else
                expected_normals.push_back(cross_prod(prev_vec, cur, 1'b0));
            prev_vec = cur;
            if (last) begin
                expected_normals.push_back(cross_prod(cur, first_vec, 1'b1));
                open_polygon = 0;
            end
        endfunction

        task check_normal(normal_t got);
            normal_t e;
            if (expected_normals.size() == 0) begin
                report("normal item with no expectation");
                return;
            end
            e = expected_normals.pop_front();
            if (got.nx !== e.nx)
                report($sformatf("normal_x got %0d exp %0d", got.nx, e.nx));
            if (got.ny !== e.ny)
                report($sformatf("normal_y got %0d exp %0d", got.ny, e.ny));
            if (got.nz !== e.nz)
                report($sformatf("normal_z got %0d exp %0d", got.nz, e.nz));
            if (got.closing !== e.closing)
                report($sformatf("closing_edge got %0b exp %0b", got.closing, e.closing));
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    spen_vtx_if vin();
    spen_nrm_if nout();
    normal_board board;
    int send_idle_pct = 0;
    int stall_pct = 0;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    sky_polygon_edge_normals_unit u_top (.clk(clk), .rst_n(rst_n), .vin(vin), .nout(nout));

    initial
    begin
        vin.valid = 0;
        vin.ra_deg = 0;
        vin.dec_deg = 0;
        vin.last_vertex = 0;
        nout.ready = 0;
    end

    // receiver: random stalls, check on accept
    always @(posedge clk)
    begin
        normal_t got;
        if (rst_n) begin
            if (nout.valid && nout.ready) begin
                got.nx = nout.normal_x;
                got.ny = nout.normal_y;
                got.nz = nout.normal_z;
                got.closing = nout.closing_edge;
                board.check_normal(got);
            end
            nout.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // valid stays high between back-to-back items; it drops only while idling
    task automatic send_vertex(input logic [24:0] ra, input logic signed [23:0] dec,
                               input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            vin.valid <= 0;
            @(posedge clk);
        end
        vin.valid <= 1;
        vin.ra_deg <= ra;
        vin.dec_deg <= dec;
        vin.last_vertex <= last;
        @(posedge clk);
        while (!vin.ready)
            @(posedge clk);
        board.note_vertex(ra, dec, last);
    endtask

    task automatic send_random_vertex(input logic last);
        logic [24:0] ra;
        logic signed [23:0] dec;
        if ($urandom_range(9) == 0) begin
            ra = 25'($urandom);
            dec = 24'($urandom);
        end
        else begin
            ra = 25'($urandom_range(23592960));
            dec = 24'($signed($urandom_range(11796480)) - 5898240);
        end
        send_vertex(ra, dec, last);
    endtask

    initial
    begin
        int n, len;
        board = new();
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: extremes, single-vertex polygon, out-of-range angles
        send_vertex(25'd0, 24'sd0, 1'b1);
        send_vertex(25'd23592960, 24'sd5898240, 1'b0);
        send_vertex(25'd0, -24'sd5898240, 1'b0);
        send_vertex(25'd11796480, 24'sd0, 1'b1);
        send_vertex(25'h1FFFFFF, 24'sh7FFFFF, 1'b0);
        send_vertex(25'h0, 24'sh800000, 1'b0);
        send_vertex(25'd5898240, 24'sh7FFFFF, 1'b0);
        send_vertex(25'h1555555, 24'sh2AAAAA, 1'b1);
        send_vertex(25'd17694720, 24'sd2949120, 1'b1);
        send_vertex(25'd1, -24'sd1, 1'b0);
        send_vertex(25'h0AAAAAA, 24'sh555555, 1'b1);
        n = 11;
        while (n < 1000) begin
            case ((n / 120) % 4)
                0: begin send_idle_pct = 0; stall_pct = 0; end
                1: begin send_idle_pct = 75; stall_pct = 0; end
                2: begin send_idle_pct = 0; stall_pct = 75; end
                default: begin send_idle_pct = 22; stall_pct = 22; end
            endcase
            len = ($urandom_range(7) == 0) ? 1 : int'($urandom_range(8, 2));
            for (int k = 0; k < len; k++)
                send_random_vertex(k == len - 1);
            n += len;
        end
        vin.valid <= 0;
        while (board.expected_normals.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("PASS sky_polygon_edge_normals_unit");
        else
            $display("FAIL sky_polygon_edge_normals_unit");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAIL sky_polygon_edge_normals_unit");
        $finish;
    end
endmodule

### sky_polygon_edge_normals_unit.f
design/spen_pkg.sv
design/spen_if.sv
design/spen_front.sv
design/spen_back.sv
design/sky_polygon_edge_normals_unit.sv
sim/tb.sv
